// ----- src/apr_pkg.sv -----
// Package for the arm pose regulator: constants, tables, types.
package apr_pkg;

  localparam int FX = 24;
  localparam int W = 40;            // internal Q.24 word width
  localparam int CORDIC_STEPS = 24;
  localparam logic signed [W-1:0] PI_FX = 40'sd52707179;
  localparam logic signed [W-1:0] HALF_PI_FX = 40'sd26353589;
  localparam logic signed [W-1:0] TWO_PI_FX = 40'sd105414357;
  localparam logic signed [W-1:0] CORDIC_K = 40'sd10188014;
  localparam logic signed [W-1:0] ONE_FX = 40'sd16777216;
  localparam logic signed [W-1:0] HALF_SQRT2 = 40'sd11863283;
  localparam logic signed [W-1:0] BASE_Y = 40'sd7381975;
  localparam logic signed [W-1:0] BASE_Z = 40'sd335544;
  localparam int DEF_JOINTS = 7;
  localparam int DEF_ANGLE_FRAC_BITS = 12;

  // register indexes
  localparam logic [2:0] REG_LGAIN = 3'd0;
  localparam logic [2:0] REG_AGAIN = 3'd1;
  localparam logic [2:0] REG_TX = 3'd2;
  localparam logic [2:0] REG_TY = 3'd3;
  localparam logic [2:0] REG_TZ = 3'd4;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TRIG, ST_CORDIC, ST_LINK, ST_MAC, ST_ERR, ST_OUT_MAC, ST_GAIN, ST_DONE
  } state_t;

  function automatic logic signed [W-1:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0: atan_lut = 40'sd13176795;
      5'd1: atan_lut = 40'sd7778716;
      5'd2: atan_lut = 40'sd4110060;
      5'd3: atan_lut = 40'sd2086331;
      5'd4: atan_lut = 40'sd1047214;
      5'd5: atan_lut = 40'sd524117;
      5'd6: atan_lut = 40'sd262123;
      5'd7: atan_lut = 40'sd131069;
      default: atan_lut = (i < 5'd24) ? (40'sd1 <<< (5'd24 - i)) : 40'sd0;
    endcase
  endfunction

  function automatic logic signed [W-1:0] link_d(input logic [2:0] j);
    case (j)
      3'd0: link_d = 40'sd4778151;
      3'd1: link_d = -40'sd197971;
      3'd2: link_d = 40'sd7059852;
      3'd3: link_d = -40'sd214748;
      3'd4: link_d = 40'sd5273079;
      3'd6: link_d = 40'sd2808506;
      default: link_d = 40'sd0;
    endcase
  endfunction

  // rounding shift right by n of a wide product
  function automatic logic signed [W-1:0] rnd_sh(input logic signed [79:0] v,
                                                 input logic [4:0] n);
    logic signed [79:0] t;
    t = (v + (80'sd1 <<< (n - 5'd1))) >>> n;
    rnd_sh = t[W-1:0];
  endfunction

endpackage

// ----- src/apr_stream_if.sv -----
// Valid/ready channel interface carrying one payload struct.
interface apr_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/apr_cordic.sv -----
// Iterative CORDIC sine/cosine, one rotation per cycle.
module apr_cordic
  import apr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [W-1:0] angle,
  output logic                done,
  output logic signed [W-1:0] sin_o,
  output logic signed [W-1:0] cos_o
);
  logic signed [W-1:0] x, y, z;
  logic [4:0] step;
  logic busy, neg;
  logic signed [W-1:0] z0, z1;
  logic neg1;

  // fold angle into [-pi/2, pi/2]
  always_comb begin
    z0 = angle;
    if (z0 > PI_FX) z0 = z0 - TWO_PI_FX;
    else if (z0 < -PI_FX) z0 = z0 + TWO_PI_FX;
    z1 = z0;
    neg1 = 1'b0;
    if (z0 > HALF_PI_FX) begin
      z1 = z0 - PI_FX;
      neg1 = 1'b1;
    end else if (z0 < -HALF_PI_FX) begin
      z1 = z0 + PI_FX;
      neg1 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        x <= CORDIC_K;
        y <= '0;
        z <= z1;
        neg <= neg1;
        step <= '0;
      end else if (busy) begin
        if (!z[W-1]) begin
          x <= x - (y >>> step);
          y <= y + (x >>> step);
          z <= z - atan_lut(step);
        end else begin
          x <= x + (y >>> step);
          y <= y - (x >>> step);
          z <= z + atan_lut(step);
        end
        step <= step + 5'd1;
        if (step == 5'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sin_o = neg ? -y : y;
  assign cos_o = neg ? -x : x;
endmodule

// ----- src/arm_pose_regulator.sv -----
// Top level of the arm pose regulator.
// Usage: items arrive on in_ch (cmd 0 stores joint angles, cmd 1 is a control
// tick); each tick yields one twist on out_ch. Gains and target are written
// through the plain cfg port (cfg_we, cfg_index, cfg_data); the user must do
// so only while idle, as the block itself does not enforce it. A tick runs,
// per link, a start state, the 24-step CORDIC, 12 matrix entries each built by
// three passes through one shared 32x32 multiply-accumulate unit and a commit
// state; then an error step and the output and gain products through the same
// unit. A tick before any sample, after stop or with a stop request goes
// straight to the done state and returns a zero twist.
// in_ch.ready is low while a tick is in progress or while a result waits.
// The result register holds the twist until out_ch.ready; the block then
// takes the next item. Reset clears the joint store, the sample flag, the
// stop latch and restores the register defaults.
module arm_pose_regulator
  import apr_pkg::*;
#(
  parameter int JOINTS = DEF_JOINTS,
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  apr_stream_if.sink   in_ch,
  apr_stream_if.source out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int JW = $clog2(JOINTS);
  localparam logic signed [16:0] LAST_OFFSET =
    17'((2 * (1 << ANGLE_FRAC_BITS) + 5) / 10);

  logic [15:0] lgain, again;
  logic signed [15:0] tgt [3];
  logic signed [15:0] jstore [JOINTS];
  logic have_sample, stopped;
  state_t state, state_next;

  logic signed [W-1:0] t [3][4];
  logic signed [W-1:0] n [3][4];
  logic signed [W-1:0] s, c, e [3], wv [3], r6 [6];
  logic [JW-1:0] link;
  logic [1:0] row, k;
  logic [2:0] col;
  logic signed [79:0] acc;
  logic out_valid;
  logic signed [23:0] res [6];
  logic active_r;

  logic cstart, cdone;
  logic signed [W-1:0] csin, ccos, cang;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      lgain <= 16'd128;
      again <= 16'd2560;
      tgt[0] <= '0;
      tgt[1] <= '0;
      tgt[2] <= 16'sd1434;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LGAIN: lgain <= cfg_data;
        REG_AGAIN: again <= cfg_data;
        REG_TX: tgt[0] <= cfg_data;
        REG_TY: tgt[1] <= cfg_data;
        REG_TZ: tgt[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cang = (link[0] == 1'b0)
    ? -(W'(jstore[link]) <<< (FX - ANGLE_FRAC_BITS))
    : (W'(jstore[link]) <<< (FX - ANGLE_FRAC_BITS));

  apr_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cstart), .angle(cang),
    .done(cdone), .sin_o(csin), .cos_o(ccos)
  );

  // link matrix entry a[k][col] for the current link
  function automatic logic signed [W-1:0] a_ent(input logic [1:0] kk, input logic [2:0] cc,
                                                input logic signed [W-1:0] sv,
                                                input logic signed [W-1:0] cv,
                                                input logic last, input logic sgn,
                                                input logic [JW-1:0] lk);
    logic signed [W-1:0] sa, ca;
    sa = last ? '0 : (sgn ? ONE_FX : -ONE_FX);
    ca = last ? ONE_FX : '0;
    a_ent = '0;
    case (kk)
      2'd0: case (cc)
        3'd0: a_ent = cv;
        3'd1: a_ent = last ? -sv : '0;
        3'd2: a_ent = last ? '0 : (sgn ? sv : -sv);
        default: a_ent = '0;
      endcase
      2'd1: case (cc)
        3'd0: a_ent = sv;
        3'd1: a_ent = last ? cv : '0;
        3'd2: a_ent = last ? '0 : (sgn ? -cv : cv);
        default: a_ent = '0;
      endcase
      2'd2: case (cc)
        3'd1: a_ent = sa;
        3'd2: a_ent = ca;
        3'd3: a_ent = link_d(3'(lk));
        default: a_ent = '0;
      endcase
      default: a_ent = '0;
    endcase
  endfunction

  // shared multiplier operands; every operand fits in 32 bits signed
  logic signed [W-1:0] ma, mb;
  logic signed [31:0] ma32, mb32;
  logic signed [63:0] mul;
  logic signed [79:0] prod;
  logic last_link;
  assign last_link = (link == JW'(JOINTS - 1));

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_MAC: begin
        ma = t[row][k];
        mb = a_ent(k, col, s, c, last_link, link[0], link);
      end
      ST_OUT_MAC: begin
        ma = t[k][row];
        mb = col[0] ? wv[k] : e[k];
      end
      ST_GAIN: begin
        ma = r6[{1'b0, row} + (col[0] ? 3'd3 : 3'd0)];
        mb = col[0] ? W'(again) : W'(lgain);
      end
      default: ;
    endcase
  end
  assign ma32 = ma[31:0];
  assign mb32 = mb[31:0];
  assign mul = ma32 * mb32;
  assign prod = 80'(mul);

  // sequencer
  always_comb begin
    state_next = state;
    cstart = 1'b0;
    case (state)
      ST_IDLE: if (in_ch.valid && !out_valid && in_ch.data.cmd == CMD_TICK) begin
        state_next = (!have_sample || stopped || in_ch.data.stop_request) ? ST_DONE : ST_TRIG;
      end
      ST_TRIG: begin
        cstart = 1'b1;
        state_next = ST_CORDIC;
      end
      ST_CORDIC: if (cdone) state_next = ST_MAC;
      ST_MAC: if (k == 2'd2 && col == 3'd3 && row == 2'd2) state_next = ST_LINK;
      ST_LINK: state_next = last_link ? ST_ERR : ST_TRIG;
      ST_ERR: state_next = ST_OUT_MAC;
      ST_OUT_MAC: if (k == 2'd2 && row == 2'd2 && col[0]) state_next = ST_GAIN;
      ST_GAIN: if (row == 2'd2 && col[0]) state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state == ST_IDLE) && !out_valid;

  function automatic logic signed [23:0] sat24(input logic signed [W-1:0] v);
    if (v > 40'sd8388607) sat24 = 24'sh7FFFFF;
    else if (v < -40'sd8388608) sat24 = 24'sh800000;
    else sat24 = v[23:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      have_sample <= 1'b0;
      stopped <= 1'b0;
      out_valid <= 1'b0;
      for (int j = 0; j < JOINTS; j++) jstore[j] <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.data.stop_request) stopped <= 1'b1;
        if (in_ch.data.cmd == CMD_SAMPLE) begin
          jstore[0] <= in_ch.data.joint_0;
          jstore[1] <= in_ch.data.joint_1;
          jstore[2] <= in_ch.data.joint_2;
          jstore[3] <= in_ch.data.joint_3;
          jstore[4] <= in_ch.data.joint_4;
          jstore[5] <= in_ch.data.joint_5;
          if (17'(in_ch.data.joint_6) + LAST_OFFSET > 17'sd32767) jstore[JOINTS-1] <= 16'sh7FFF;
          else jstore[JOINTS-1] <= 16'(17'(in_ch.data.joint_6) + LAST_OFFSET);
          have_sample <= 1'b1;
        end else begin
          active_r <= !(!have_sample || stopped || in_ch.data.stop_request);
          // base transform
          t[0][0] <= HALF_SQRT2; t[0][1] <= HALF_SQRT2; t[0][2] <= '0; t[0][3] <= '0;
          t[1][0] <= -HALF_SQRT2; t[1][1] <= HALF_SQRT2; t[1][2] <= '0; t[1][3] <= BASE_Y;
          t[2][0] <= '0; t[2][1] <= '0; t[2][2] <= ONE_FX; t[2][3] <= BASE_Z;
          link <= '0;
          for (int i = 0; i < 6; i++) r6[i] <= '0;
        end
      end
      case (state)
        ST_TRIG: begin
          row <= '0; col <= '0; k <= '0; acc <= '0;
        end
        ST_CORDIC: if (cdone) begin
          s <= csin;
          c <= ccos;
        end
        ST_MAC: begin
          if (k == 2'd2) begin
            n[row][col[1:0]] <= rnd_sh(acc + prod, 5'd24) + ((col == 3'd3) ? t[row][3] : '0);
            acc <= '0;
            k <= '0;
            if (col == 3'd3) begin
              col <= '0;
              row <= row + 2'd1;
            end else col <= col + 3'd1;
          end else begin
            acc <= acc + prod;
            k <= k + 2'd1;
          end
        end
        ST_LINK: begin
          t <= n;
          link <= link + JW'(1);
        end
        ST_ERR: begin
          for (int i = 0; i < 3; i++)
            e[i] <= (W'(tgt[i]) <<< (FX - ANGLE_FRAC_BITS)) - t[i][3];
          wv[0] <= t[1][1] + t[2][2];
          wv[1] <= t[2][0] - t[0][1];
          wv[2] <= -t[0][2] - t[1][0];
          row <= '0; col <= '0; k <= '0; acc <= '0;
        end
        ST_OUT_MAC: begin
          // col[0] = 0: linear product, 1: angular product
          if (k == 2'd2) begin
            r6[{1'b0, row} + (col[0] ? 3'd3 : 3'd0)] <=
              rnd_sh(acc + prod, col[0] ? 5'd25 : 5'd24);
            acc <= '0;
            k <= '0;
            if (col[0]) begin
              col <= '0;
              row <= (row == 2'd2) ? 2'd0 : row + 2'd1;
            end else col <= 3'd1;
          end else begin
            acc <= acc + prod;
            k <= k + 2'd1;
          end
        end
        ST_GAIN: begin
          res[{1'b0, row} + (col[0] ? 3'd3 : 3'd0)] <= sat24(rnd_sh(prod, 5'd16));
          if (col[0]) begin
            col <= '0;
            row <= row + 2'd1;
          end else col <= 3'd1;
        end
        ST_DONE: begin
          out_valid <= 1'b1;
          if (!active_r) for (int i = 0; i < 6; i++) res[i] <= '0;
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data.linear_x = res[0];
  assign out_ch.data.linear_y = res[1];
  assign out_ch.data.linear_z = res[2];
  assign out_ch.data.angular_x = res[3];
  assign out_ch.data.angular_y = res[4];
  assign out_ch.data.angular_z = res[5];
  assign out_ch.data.active = active_r;

  // a result is only raised from the final state
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE) else $error("unexpected result");
  // no intake while a result waits
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ch.ready) else $error("took item while result pending");
  // stop latch never clears
  a_stop: assert property (@(posedge clk) disable iff (rst)
    $past(stopped) |-> stopped) else $error("stop latch cleared");
endmodule
